@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the grid sync qualifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, ignored while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/core/gsq_pkg.sv @@
// Types and constants shared by the grid sync qualifier modules.
package gsq_pkg;

  // Fixed field widths.
  localparam int TIME_W     = 16;
  localparam int HALF_W     = 15;
  localparam int VOLT_W     = 12;
  localparam int CYCLE_W    = 8;
  localparam int ACTION_W   = 3;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Event kinds carried by one input transaction.
  typedef enum logic [ACTION_W-1:0] {
    ACT_RISE    = 3'd0,
    ACT_FALL    = 3'd1,
    ACT_POLL    = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  // Line polarity of the current half cycle.
  typedef enum logic [POL_W-1:0] {
    POL_UNKNOWN = 2'd0,
    POL_POS     = 2'd1,
    POL_NEG     = 2'd2
  } pol_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MARGIN = 3'd0,
    CFG_WIDTH_MIN     = 3'd1,
    CFG_WIDTH_MAX     = 3'd2,
    CFG_VOLT_MIN      = 3'd3,
    CFG_VOLT_MAX      = 3'd4,
    CFG_POS_THRESHOLD = 3'd5,
    CFG_VOLTAGE_MODE  = 3'd6
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [TIME_W-1:0] PERIOD_MARGIN_RST = 16'd400;
  localparam logic [TIME_W-1:0] WIDTH_MIN_RST     = 16'd100;
  localparam logic [TIME_W-1:0] WIDTH_MAX_RST     = 16'd2000;
  localparam logic [VOLT_W-1:0] VOLT_MIN_RST      = 12'd500;
  localparam logic [VOLT_W-1:0] VOLT_MAX_RST      = 12'd3500;
  localparam logic [VOLT_W-1:0] POS_THRESHOLD_RST = 12'd100;

endpackage

@@ rtl/core/gsq_in_if.sv @@
// Valid/ready channel that carries one sync event transaction.
interface gsq_in_if #(
  parameter int SAMPLE_BITS = 12
);
  import gsq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [TIME_W-1:0]      phase_count;
  logic [TIME_W-1:0]      silence_count;
  logic [SAMPLE_BITS-1:0] line_sample;

  modport source (
    output valid, action, phase_count, silence_count, line_sample,
    input  ready
  );

  modport sink (
    input  valid, action, phase_count, silence_count, line_sample,
    output ready
  );

endinterface

@@ rtl/core/gsq_out_if.sv @@
// Valid/ready channel that carries one qualifier status transaction.
interface gsq_out_if #(
  parameter int SAMPLE_BITS = 12
);
  import gsq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   all_good;
  logic                   frequency_good;
  logic                   pulses_good;
  logic                   voltage_good;
  logic [POL_W-1:0]       polarity;
  logic [TIME_W-1:0]      period_average;
  logic [HALF_W-1:0]      half_width_average;
  logic [CYCLE_W-1:0]     cycle_count;
  logic [SAMPLE_BITS-1:0] line_peak;

  modport source (
    output valid, all_good, frequency_good, pulses_good, voltage_good, polarity,
           period_average, half_width_average, cycle_count, line_peak,
    input  ready
  );

  modport sink (
    input  valid, all_good, frequency_good, pulses_good, voltage_good, polarity,
           period_average, half_width_average, cycle_count, line_peak,
    output ready
  );

endinterface

@@ rtl/core/gsq_avg.sv @@
// Moving average over a ring of the last DEPTH values, ring held in a memory.
module gsq_avg #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      clear,
  input  logic [gsq_pkg::TIME_W-1:0] value,
  output logic [gsq_pkg::TIME_W-1:0] avg
);
  import gsq_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int SUM_W  = TIME_W + SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [TIME_W-1:0] rd_q;
  logic [TIME_W-1:0] oldest;

  // Oldest entry; an entry not written since the last clear reads as zero.
  assign oldest   = valid[slot] ? rd_q : '0;
  assign sum_next = sum - SUM_W'(oldest) + SUM_W'(value);
  assign avg      = TIME_W'(sum_next / DEPTH);

  // Slot that the next transaction will replace.
  always_comb begin
    slot_next = slot;
    if (clear) begin
      slot_next = '0;
    end else if (push) begin
      slot_next = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    end
  end

  // Ring storage; the entry at the upcoming slot is read into a register ahead of use.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[slot] <= value;
    end
    rd_q <= mem[slot_next];
  end

  // Running sum, write slot and per-entry valid bits.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      sum   <= '0;
      slot  <= '0;
    end else if (push) begin
      valid[slot] <= 1'b1;
      sum         <= sum_next;
      slot        <= slot_next;
    end
  end

endmodule

@@ rtl/core/gsq_qual.sv @@
// Qualifier state: averages, window checks, timeout, polarity and voltage.
module gsq_qual #(
  parameter int AVG_DEPTH   = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [gsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsq_pkg::CFG_DATA_W-1:0] cfg_data,
  // Event being retired this cycle
  input  logic                          step,
  input  logic [gsq_pkg::ACTION_W-1:0]   action,
  input  logic [gsq_pkg::TIME_W-1:0]     phase_count,
  input  logic [gsq_pkg::TIME_W-1:0]     silence_count,
  input  logic [SAMPLE_BITS-1:0]        line_sample,
  // Current status
  output logic                          all_good,
  output logic                          frequency_good,
  output logic                          pulses_good,
  output logic                          voltage_good,
  output logic [gsq_pkg::POL_W-1:0]      polarity,
  output logic [gsq_pkg::TIME_W-1:0]     period_average,
  output logic [gsq_pkg::HALF_W-1:0]     half_width_average,
  output logic [gsq_pkg::CYCLE_W-1:0]    cycle_count,
  output logic [SAMPLE_BITS-1:0]        line_peak
);
  import gsq_pkg::*;

  // Configuration registers
  logic [TIME_W-1:0] period_margin;
  logic [TIME_W-1:0] width_min;
  logic [TIME_W-1:0] width_max;
  logic [VOLT_W-1:0] volt_min;
  logic [VOLT_W-1:0] volt_max;
  logic [VOLT_W-1:0] pos_threshold;
  logic              voltage_mode;

  // Status registers and their next values
  logic                   freq_ok, freq_ok_next;
  logic                   pulse_ok, pulse_ok_next;
  logic                   volt_ok, volt_ok_next;
  logic                   pending, pending_next;
  pol_t                   pol, pol_next;
  logic [CYCLE_W-1:0]     cycles, cycles_next;
  logic [SAMPLE_BITS-1:0] peak, peak_next;
  logic [TIME_W-1:0]      period_avg, period_avg_next;
  logic [HALF_W-1:0]      half_width, half_width_next;

  // Decode and datapath
  logic              push_period;
  logic              push_width;
  logic              clear_rings;
  logic [TIME_W-1:0] period_avg_new;
  logic [TIME_W-1:0] width_avg_new;
  logic              freq_new;
  logic              pulse_new;
  logic              timeout;
  logic              half_due;
  logic              sample_pos;
  logic              sample_in_range;
  logic [TIME_W-1:0] sample_ext;

  assign push_period = step && (action_t'(action) == ACT_RISE);
  assign push_width  = step && (action_t'(action) == ACT_FALL);
  assign clear_rings = step && (action_t'(action) == ACT_RESTART);

  gsq_avg #(.DEPTH(AVG_DEPTH)) u_period_avg (
    .clk   (clk),
    .rst   (rst),
    .push  (push_period),
    .clear (clear_rings),
    .value (phase_count),
    .avg   (period_avg_new)
  );

  gsq_avg #(.DEPTH(AVG_DEPTH)) u_width_avg (
    .clk   (clk),
    .rst   (rst),
    .push  (push_width),
    .clear (clear_rings),
    .value (phase_count),
    .avg   (width_avg_new)
  );

  // Period window round the new average; the lower bound may go negative.
  assign freq_new = (phase_count > period_margin) &&
                    (({1'b0, phase_count} + {1'b0, period_margin}) >
                     {1'b0, period_avg_new}) &&
                    ({1'b0, phase_count} <
                     ({1'b0, period_avg_new} + {1'b0, period_margin}));

  assign pulse_new = (phase_count < width_max) && (phase_count > width_min);

  // Silence limit is the average period plus twice the margin.
  assign timeout = {2'b00, silence_count} >
                   ({2'b00, period_avg} + {1'b0, period_margin, 1'b0});

  // Half a cycle has passed once the phase passes half period plus half width.
  assign half_due = {1'b0, phase_count} >
                    ({2'b00, period_avg[TIME_W-1:1]} + {2'b00, half_width});

  assign sample_ext      = TIME_W'(line_sample);
  assign sample_pos      = sample_ext > TIME_W'(pos_threshold);
  assign sample_in_range = (sample_ext > TIME_W'(volt_min)) &&
                           (sample_ext < TIME_W'(volt_max));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_margin <= PERIOD_MARGIN_RST;
      width_min     <= WIDTH_MIN_RST;
      width_max     <= WIDTH_MAX_RST;
      volt_min      <= VOLT_MIN_RST;
      volt_max      <= VOLT_MAX_RST;
      pos_threshold <= POS_THRESHOLD_RST;
      voltage_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PERIOD_MARGIN: period_margin <= cfg_data;
        CFG_WIDTH_MIN:     width_min     <= cfg_data;
        CFG_WIDTH_MAX:     width_max     <= cfg_data;
        CFG_VOLT_MIN:      volt_min      <= cfg_data[VOLT_W-1:0];
        CFG_VOLT_MAX:      volt_max      <= cfg_data[VOLT_W-1:0];
        CFG_POS_THRESHOLD: pos_threshold <= cfg_data[VOLT_W-1:0];
        CFG_VOLTAGE_MODE:  voltage_mode  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Next status for the event being retired
  always_comb begin
    freq_ok_next    = freq_ok;
    pulse_ok_next   = pulse_ok;
    volt_ok_next    = volt_ok;
    pending_next    = pending;
    pol_next        = pol;
    cycles_next     = cycles;
    peak_next       = peak;
    period_avg_next = period_avg;
    half_width_next = half_width;
    if (step) begin
      unique case (action_t'(action))
        ACT_RISE: begin
          period_avg_next = period_avg_new;
          freq_ok_next    = freq_new;
        end
        ACT_FALL: begin
          cycles_next     = cycles + 1'b1;
          half_width_next = width_avg_new[TIME_W-1:1];
          pulse_ok_next   = pulse_new;
          if (freq_ok && pulse_new) begin
            pending_next = 1'b1;
          end
        end
        ACT_POLL: begin
          if (timeout) begin
            freq_ok_next  = 1'b0;
            pulse_ok_next = 1'b0;
          end
          if (pending && half_due) begin
            pending_next = 1'b0;
            // In positive-only mode the voltage is checked on positive halves.
            if (!voltage_mode || sample_pos) begin
              peak_next    = line_sample;
              volt_ok_next = sample_in_range;
            end
            if (sample_pos) begin
              pol_next = (pol != POL_POS) ? POL_POS : POL_UNKNOWN;
            end else begin
              pol_next = (pol != POL_NEG) ? POL_NEG : POL_UNKNOWN;
            end
          end
        end
        ACT_RESTART: begin
          freq_ok_next  = 1'b0;
          pulse_ok_next = 1'b0;
          volt_ok_next  = 1'b0;
          pol_next      = POL_UNKNOWN;
        end
        ACT_CLEAR: begin
          cycles_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_ok    <= 1'b0;
      pulse_ok   <= 1'b0;
      volt_ok    <= 1'b1;
      pending    <= 1'b0;
      pol        <= POL_UNKNOWN;
      cycles     <= '0;
      peak       <= '0;
      period_avg <= '0;
      half_width <= '0;
    end else begin
      freq_ok    <= freq_ok_next;
      pulse_ok   <= pulse_ok_next;
      volt_ok    <= volt_ok_next;
      pending    <= pending_next;
      pol        <= pol_next;
      cycles     <= cycles_next;
      peak       <= peak_next;
      period_avg <= period_avg_next;
      half_width <= half_width_next;
    end
  end

  assign all_good           = freq_ok && pulse_ok && volt_ok;
  assign frequency_good     = freq_ok;
  assign pulses_good        = pulse_ok;
  assign voltage_good       = volt_ok;
  assign polarity           = pol;
  assign period_average     = period_avg;
  assign half_width_average = half_width;
  assign cycle_count        = cycles;
  assign line_peak          = peak;

endmodule

@@ rtl/core/grid_sync_qualifier_unit.sv @@
// Top level of the grid sync qualifier: event register, handshake and status channel.
//
// Usage: each transaction on evt carries one sync event (rising edge, falling
// edge, poll, restart or clear cycle count) with the phase and silence timer
// values and a line voltage sample. For every accepted event exactly one
// transaction leaves on status with the qualifier state after that event.
// Configuration registers are written through cfg_we/cfg_index/cfg_data while
// the block is idle; indexes with no register are ignored.
// An accepted event is held in the event register and retired once the status
// slot is free or being taken; its status is registered as it retires.
// Throughput: one event per cycle while status is taken. The two average
// rings read their oldest entry ahead of use from a registered memory port,
// so back-to-back events never wait on the ring read.
// Reset (synchronous, active high) restores the configuration defaults and
// the qualifier state; the ring entries are masked by valid bits, so there
// is no clearing pass.
// Stall: while status is held, the event register keeps one more event and
// evt.ready falls until status is taken.
`include "assert_macros.svh"

module grid_sync_qualifier_unit #(
  parameter int AVG_DEPTH   = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  gsq_in_if.sink                        evt,
  gsq_out_if.source                     status,
  input  logic                          cfg_we,
  input  logic [gsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsq_pkg::*;

  // Event register
  logic                   s1_valid;
  logic [ACTION_W-1:0]    s1_action;
  logic [TIME_W-1:0]      s1_phase;
  logic [TIME_W-1:0]      s1_silence;
  logic [SAMPLE_BITS-1:0] s1_sample;

  logic status_valid;
  logic advance;
  logic step;

  // The held event retires when the status slot is free or being taken.
  assign advance   = !status_valid || status.ready;
  assign step      = s1_valid && advance;
  assign evt.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      s1_action  <= evt.action;
      s1_phase   <= evt.phase_count;
      s1_silence <= evt.silence_count;
      s1_sample  <= evt.line_sample;
    end
  end

  // Status transaction valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= s1_valid;
    end
  end

  assign status.valid = status_valid;

  gsq_qual #(
    .AVG_DEPTH   (AVG_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_qual (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .step               (step),
    .action             (s1_action),
    .phase_count        (s1_phase),
    .silence_count      (s1_silence),
    .line_sample        (s1_sample),
    .all_good           (status.all_good),
    .frequency_good     (status.frequency_good),
    .pulses_good        (status.pulses_good),
    .voltage_good       (status.voltage_good),
    .polarity           (status.polarity),
    .period_average     (status.period_average),
    .half_width_average (status.half_width_average),
    .cycle_count        (status.cycle_count),
    .line_peak          (status.line_peak)
  );

  // A held event that cannot retire must block the input channel.
  `ASSERT_CLK(a_no_overwrite, clk, rst, s1_valid && !advance |-> !evt.ready, "held event overwritten")
  // Every retired event shows up as a status transaction.
  `ASSERT_CLK(a_step_gives_status, clk, rst, step |=> status.valid, "retired event lost")
  // With nothing held and no status pending, no status transaction appears.
  `ASSERT_CLK(a_no_invented, clk, rst, !s1_valid && !status_valid |=> !status.valid, "status invented")

endmodule
